>>> sv/xrg_pkg.sv
// Package for the seeded xorshift range generator.
// Holds the opcode codes, the seed-expansion constants and the reset image of
// the generator words. No dependencies.
package xrg_pkg;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_RAW     = 2'd0,
    OP_RANGE   = 2'd1,
    OP_RESTART = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_t;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXP  = 5'b00010,
    ST_DRAW = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  // Seed expansion constants
  localparam logic [31:0] K_W0   = 32'd2654435761;
  localparam logic [31:0] K_W2   = 32'd3735928559;
  localparam logic [63:0] X_W2   = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] X_W3   = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] K_W3   = 64'd27916243729;
  localparam logic [31:0] X_W3LO = X_W3[31:0];
  localparam logic [31:0] X_W3HI = X_W3[63:32];
  localparam logic [31:0] K_W3LO = K_W3[31:0];
  localparam logic [31:0] K_W3HI = K_W3[63:32];

  // The seed only covers the low half of the xor mask, so the high half
  // times the low constant half is a fixed term of w3.
  localparam logic [63:0] W3_FIX_PROD = 64'(X_W3HI) * 64'(K_W3LO);
  localparam logic [63:0] W3_FIX      = W3_FIX_PROD << 32;

  // Generator words and seed after reset
  localparam logic [31:0] SEED_RST = 32'd1;
  localparam logic [63:0] W0_RST   = 64'(SEED_RST) * 64'(K_W0);
  localparam logic [63:0] W1_RST   = 64'd0;
  localparam logic [63:0] W2_PROD  = 64'(SEED_RST) * 64'(K_W2);
  localparam logic [63:0] W2_RST   = W2_PROD ^ X_W2;
  localparam logic [63:0] W3_XOR   = 64'(SEED_RST) ^ X_W3;
  localparam logic [63:0] W3_RST   = W3_XOR * K_W3;

  // Output shift of a raw draw
  localparam int unsigned DRAW_SHIFT = 27;

endpackage

>>> sv/seeded_xorshift_range_generator.sv
// Seeded xorshift range generator, top level.
// Depends on xrg_pkg for opcodes, states and seed-expansion constants.
// ---------------------------------------------------------------------------
// Usage:
//   Input word (in_valid / in_stall): opcode, range_low, range_high. Opcode
//   raw gives a 64-bit draw, range gives low + draw mod (high-low+1) (low if
//   low >= high, words not advanced), restart re-expands the seed, giving 0.
//   Result word (out_valid / out_stall): value, one per input word, held in
//   an output register; the next input word is taken while it waits.
//   Seed port (cfg_valid / cfg_ready): a write re-expands the generator words
//   through the shared multiplier; input is stalled meanwhile.
// Sequencing (acceptance to out_valid):
//   raw draw via the draw and result states; range draw via the draw state,
//   a two-bit-per-cycle restoring remainder unit and the result state; empty
//   range or unused opcode straight to the result state; restart via four
//   passes through the shared 32x32 multiplier. One word at a time; in_stall
//   stays high until the result is loaded into the output register.
// Reset (rst_n, synchronous): seed = 1 and the generator words take the
//   expansion of seed 1 at once; no result pending.
// Receiver stall: a finished word waits in the sequencer until the output
//   register is free; the payload holds while out_stall is high.
// ---------------------------------------------------------------------------
module seeded_xorshift_range_generator (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_range_low,
  input  logic [31:0] in_range_high,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_value,
  // seed write port
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_seed_value
);
  import xrg_pkg::*;

  // Control state
  state_t      state_r, state_nxt;
  logic [1:0]  exp_cnt_r, exp_cnt_nxt;
  logic [4:0]  div_cnt_r, div_cnt_nxt;
  logic        exp_reply_r, exp_reply_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Payload state
  logic [31:0] seed_r, seed_nxt;
  logic [63:0] w0_r, w1_r, w2_r, w3_r;
  logic [63:0] w0_nxt, w1_nxt, w2_nxt, w3_nxt;
  opcode_t     op_r, op_nxt;
  logic [31:0] lo_r, lo_nxt;
  logic [32:0] span_r, span_nxt;
  logic [63:0] num_r, num_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] out_value_r, out_value_nxt;

  // Handshakes
  logic in_acc, cfg_acc, out_free;
  opcode_t in_op;

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_op     = opcode_t'(in_opcode);
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  // Shared multiplier for seed expansion
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_comb begin
    mul_a = seed_r;
    mul_b = K_W0;
    case (exp_cnt_r)
      2'd0: begin
        mul_a = seed_r;
        mul_b = K_W0;
      end
      2'd1: begin
        mul_a = seed_r;
        mul_b = K_W2;
      end
      2'd2: begin
        mul_a = seed_r ^ X_W3LO;
        mul_b = K_W3LO;
      end
      default: begin
        mul_a = seed_r ^ X_W3LO;
        mul_b = K_W3HI;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Raw draw and xoshiro-style word update
  logic [63:0] sum, draw, t17, c1, d1, b1, a1, c2, d2;

  always_comb begin
    sum  = w0_r + w3_r;
    draw = sum ^ (sum >> DRAW_SHIFT);
    t17  = w1_r << 17;
    c1   = w2_r ^ w0_r;
    d1   = w3_r ^ w1_r;
    b1   = w1_r ^ c1;
    a1   = w0_r ^ d1;
    c2   = c1 ^ t17;
    d2   = {d1[18:0], d1[63:19]};
  end

  // One restoring remainder step: shift in one bit, subtract span if it fits
  function automatic logic [31:0] rem_step(input logic [31:0] r, input logic b,
                                           input logic [32:0] span);
    logic [32:0] t;
    logic [33:0] d;
    begin
      t = {r, b};
      d = {1'b0, t} - {1'b0, span};
      rem_step = d[33] ? t[31:0] : d[31:0];
    end
  endfunction

  logic [31:0] rem_a, rem_b;
  assign rem_a = rem_step(rem_r, num_r[63], span_r);
  assign rem_b = rem_step(rem_a, num_r[62], span_r);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    exp_cnt_nxt   = exp_cnt_r;
    div_cnt_nxt   = div_cnt_r;
    exp_reply_nxt = exp_reply_r;
    seed_nxt      = seed_r;
    w0_nxt        = w0_r;
    w1_nxt        = w1_r;
    w2_nxt        = w2_r;
    w3_nxt        = w3_r;
    op_nxt        = op_r;
    lo_nxt        = lo_r;
    span_nxt      = span_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    res_nxt       = res_r;
    out_value_nxt = out_value_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_acc) begin
          seed_nxt      = cfg_seed_value;
          exp_cnt_nxt   = 2'd0;
          exp_reply_nxt = 1'b0;
          state_nxt     = ST_EXP;
        end else if (in_acc) begin
          op_nxt   = in_op;
          lo_nxt   = in_range_low;
          span_nxt = {1'b0, in_range_high} - {1'b0, in_range_low} + 33'd1;
          res_nxt  = 64'd0;
          unique case (in_op)
            OP_RAW: state_nxt = ST_DRAW;
            OP_RANGE: begin
              if (in_range_low >= in_range_high) begin
                res_nxt   = {32'd0, in_range_low};
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_DRAW;
              end
            end
            OP_RESTART: begin
              exp_cnt_nxt   = 2'd0;
              exp_reply_nxt = 1'b1;
              state_nxt     = ST_EXP;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end

      // seed expansion, one multiply per cycle
      ST_EXP: begin
        exp_cnt_nxt = exp_cnt_r + 2'd1;
        case (exp_cnt_r)
          2'd0: begin
            w0_nxt = mul_p;
            w1_nxt = 64'd0;
          end
          2'd1: w2_nxt = mul_p ^ X_W2;
          2'd2: w3_nxt = mul_p;
          default: begin
            w3_nxt    = w3_r + (mul_p << 32) + W3_FIX;
            state_nxt = exp_reply_r ? ST_DONE : ST_IDLE;
          end
        endcase
      end

      ST_DRAW: begin
        w0_nxt = a1;
        w1_nxt = b1;
        w2_nxt = c2;
        w3_nxt = d2;
        if (op_r == OP_RAW) begin
          res_nxt   = draw;
          state_nxt = ST_DONE;
        end else begin
          num_nxt     = draw;
          rem_nxt     = 32'd0;
          div_cnt_nxt = 5'd0;
          state_nxt   = ST_DIV;
        end
      end

      // two remainder bits per cycle, until all 64 draw bits are shifted in
      ST_DIV: begin
        num_nxt     = num_r << 2;
        rem_nxt     = rem_b;
        div_cnt_nxt = div_cnt_r + 5'd1;
        if (div_cnt_r == 5'd31) begin
          res_nxt   = {32'd0, lo_r + rem_b};
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_value_nxt = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      exp_cnt_r   <= 2'd0;
      div_cnt_r   <= 5'd0;
      exp_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
      seed_r      <= SEED_RST;
      w0_r        <= W0_RST;
      w1_r        <= W1_RST;
      w2_r        <= W2_RST;
      w3_r        <= W3_RST;
    end else begin
      state_r     <= state_nxt;
      exp_cnt_r   <= exp_cnt_nxt;
      div_cnt_r   <= div_cnt_nxt;
      exp_reply_r <= exp_reply_nxt;
      out_valid_r <= out_valid_nxt;
      seed_r      <= seed_nxt;
      w0_r        <= w0_nxt;
      w1_r        <= w1_nxt;
      w2_r        <= w2_nxt;
      w3_r        <= w3_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    lo_r        <= lo_nxt;
    span_r      <= span_nxt;
    num_r       <= num_nxt;
    rem_r       <= rem_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
  end

`ifndef SYNTHESIS
  // remainder stays below a nonzero span while dividing
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (span_r != 33'd0) && ({1'b0, rem_r} < span_r))
    else $error("remainder out of range");

  // empty or inverted range goes straight to the result
  a_empty_range: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_op == OP_RANGE && in_range_low >= in_range_high)
      |=> (state_r == ST_DONE) && (res_r == {32'd0, $past(in_range_low)}))
    else $error("empty range not short-cut");

  // a draw is followed by the divider or the result
  a_draw_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAW) |=> (state_r == ST_DIV) || (state_r == ST_DONE))
    else $error("bad state after draw");

  // expansion ends after its last multiply
  a_exp_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXP && exp_cnt_r == 2'd3)
      |=> (state_r == ST_IDLE) || (state_r == ST_DONE))
    else $error("seed expansion did not end");

  // result loads only into a free output register
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && out_stall) |=> (state_r == ST_DONE))
    else $error("result overwrote a stalled word");
`endif

endmodule

>>> test/xrg_draw_checker.sv
// Draw checker for the seeded xorshift range generator.
// Watches the input, result and seed channels, predicts each result word and
// compares it with what the block returns. Depends on xrg_pkg for opcode_t.
`timescale 1ns / 1ps

module xrg_draw_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_range_low,
  input  logic [31:0] in_range_high,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_value,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_seed_value,
  output int          pending,
  output int          mismatches
);
  import xrg_pkg::*;

  // Seed expansion constants
  localparam logic [31:0] SEED_AT_RESET = 32'd1;
  localparam logic [63:0] MUL_W0 = 64'd2654435761;
  localparam logic [63:0] MUL_W1 = 64'd2246822519;
  localparam logic [63:0] MUL_W2 = 64'd3735928559;
  localparam logic [63:0] XOR_W2 = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] XOR_W3 = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MUL_W3 = 64'd27916243729;
  localparam int          PRINT_CAP = 20;

  typedef struct {
    opcode_t     op;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [63:0] value;
  } draw_entry_t;

  logic [31:0] seed_reg;
  logic [63:0] gen_words [4];
  draw_entry_t expected_draws[$];
  draw_entry_t entry;
  int          error_total = 0;

  assign mismatches = error_total;

  // Print one line per mismatch (capped) and count it
  task automatic report_mismatch(input string msg);
    if (error_total < PRINT_CAP) $display("[%0t] checker: %s", $realtime, msg);
    error_total++;
  endtask

  // Expand the seed register into the four generator words
  function automatic void load_words();
    logic [63:0] s;
    s = {32'd0, seed_reg};
    gen_words[0] = s * MUL_W0;
    gen_words[1] = (s >> 32) * MUL_W1;
    gen_words[2] = (s * MUL_W2) ^ XOR_W2;
    gen_words[3] = (s ^ XOR_W3) * MUL_W3;
  endfunction

  // One raw draw: output mix of s0+s3, then advance the words
  function automatic logic [63:0] draw_next();
    logic [63:0] a, b, c, d, r, t;
    a = gen_words[0];
    b = gen_words[1];
    c = gen_words[2];
    d = gen_words[3];
    r = a + d;
    t = b << 17;
    c = c ^ a;
    d = d ^ b;
    b = b ^ c;
    a = a ^ d;
    c = c ^ t;
    d = {d[18:0], d[63:19]};   // rotate left by 45
    gen_words[0] = a;
    gen_words[1] = b;
    gen_words[2] = c;
    gen_words[3] = d;
    return r ^ (r >> 27);
  endfunction

  // Result value for one input word; updates the words as the block would
  function automatic logic [63:0] predict_value(opcode_t op, logic [31:0] lo, logic [31:0] hi);
    logic [63:0] span, v, sum;
    case (op)
      OP_RAW: return draw_next();
      OP_RANGE: begin
        // empty or inverted range gives low and leaves the words alone
        if (lo >= hi) return {32'd0, lo};
        // span reaches 2^32 for the full range, never zero
        span = {32'd0, hi} - {32'd0, lo} + 64'd1;
        v    = draw_next();
        sum  = {32'd0, lo} + (v % span);
        return {32'd0, sum[31:0]};
      end
      OP_RESTART: begin
        load_words();
        return 64'd0;
      end
      default: return 64'd0;
    endcase
  endfunction

  // Track seed writes, check results, then predict new input words
  always @(posedge clk) begin
    if (!rst_n) begin
      seed_reg = SEED_AT_RESET;
      load_words();
      expected_draws.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        seed_reg = cfg_seed_value;
        load_words();
      end
      if (out_valid && !out_stall) begin
        if (expected_draws.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing expected", out_value));
        end else begin
          entry = expected_draws.pop_front();
          if (out_value !== entry.value)
            report_mismatch($sformatf("%s lo=%h hi=%h: value %h, expected %h",
                                      entry.op.name(), entry.lo, entry.hi,
                                      out_value, entry.value));
        end
      end
      if (in_valid && !in_stall) begin
        entry.op    = opcode_t'(in_opcode);
        entry.lo    = in_range_low;
        entry.hi    = in_range_high;
        entry.value = predict_value(entry.op, in_range_low, in_range_high);
        expected_draws.push_back(entry);
      end
    end
    pending <= expected_draws.size();
  end

endmodule

>>> test/seeded_xorshift_range_generator_tb.sv
// Testbench top for the seeded xorshift range generator.
// Drives directed and random words across several seeds with random idling
// and stalls; xrg_draw_checker does the checking. Depends on xrg_pkg.
`timescale 1ns / 1ps

module seeded_xorshift_range_generator_tb;
  import xrg_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int WORDS_PER_SET = 300;
  localparam int NUM_SEEDS     = 6;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;

  typedef enum logic [1:0] {
    RX_FREE    = 2'd0,
    RX_LIGHT   = 2'd1,
    RX_PATTERN = 2'd2,
    RX_HEAVY   = 2'd3
  } rx_mode_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_opcode;
  logic [31:0] in_range_low;
  logic [31:0] in_range_high;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_seed_value;

  int pending;
  int mismatches;
  int cycle_count = 0;

  // Stimulus bookkeeping
  int burst_left = 0;
  int raw_sent = 0, range_sent = 0, empty_sent = 0, restart_sent = 0, unused_sent = 0;
  int seed_writes = 0;

  // Receiver state
  logic     hold_request = 1'b0;
  int       hold_left = 0;
  int       mode_left = 0;
  rx_mode_t rx_mode = RX_FREE;
  logic [7:0] stall_pattern = 8'h00;
  logic     stall_now;

  seeded_xorshift_range_generator i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_range_low   (in_range_low),
    .in_range_high  (in_range_high),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_seed_value (cfg_seed_value)
  );

  xrg_draw_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_range_low   (in_range_low),
    .in_range_high  (in_range_high),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_seed_value (cfg_seed_value),
    .pending        (pending),
    .mismatches     (mismatches)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: stall modes that change every so often, plus a long hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (mode_left == 0) begin
        rx_mode       = rx_mode_t'($urandom_range(0, 3));
        mode_left     = $urandom_range(20, 200);
        stall_pattern = 8'($urandom);
      end
      mode_left--;
      stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
      if (hold_left > 0) begin
        hold_left--;
        stall_now = 1'b1;
      end else begin
        case (rx_mode)
          RX_FREE:    stall_now = 1'b0;
          RX_LIGHT:   stall_now = ($urandom_range(0, 3) == 0);
          RX_PATTERN: stall_now = stall_pattern[0];
          default:    stall_now = ($urandom_range(0, 3) != 0);
        endcase
      end
      out_stall <= stall_now;
    end
  end

  // Offer one word and hold it until accepted
  task automatic send_word(input opcode_t op, input logic [31:0] lo, input logic [31:0] hi);
    @(negedge clk);
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_range_low  <= lo;
    in_range_high <= hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (op)
      OP_RAW:     raw_sent++;
      OP_RANGE:   if (lo >= hi) empty_sent++; else range_sent++;
      OP_RESTART: restart_sent++;
      default:    unused_sent++;
    endcase
  endtask

  // Drop valid for a number of cycles
  task automatic pause_input(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Stop offering and wait until every expected word has come back
  task automatic drain_results();
    pause_input(1);
    while (pending != 0) @(negedge clk);
  endtask

  // Seed write; only called with the block drained
  task automatic write_seed(input logic [31:0] seed);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_seed_value <= seed;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    seed_writes++;
  endtask

  // Range bounds of several shapes: wide, narrow, tiny, full, empty, inverted
  task automatic pick_range(output logic [31:0] lo, output logic [31:0] hi);
    logic [32:0] top;
    lo = $urandom;
    hi = $urandom;
    case ($urandom_range(0, 7))
      0: ;
      1: begin
        top = {1'b0, lo} + 33'($urandom_range(1, 1000));
        hi  = top[32] ? 32'hFFFF_FFFF : top[31:0];
      end
      2: begin
        lo = $urandom_range(0, 15);
        hi = $urandom_range(0, 15);
      end
      3: begin
        lo = 32'd0;
        hi = 32'hFFFF_FFFF;
      end
      4: hi = lo;
      5: hi = 32'hFFFF_FFFF;
      6: lo = $urandom_range(0, 3);
      default: begin
        if (lo < hi) {lo, hi} = {hi, lo};
      end
    endcase
  endtask

  // Random word, sent inside a burst with random gaps between bursts
  task automatic send_random_word();
    logic [31:0] lo, hi;
    int          pick;
    opcode_t     op;
    if (burst_left == 0) begin
      pause_input(($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    pick = $urandom_range(0, 99);
    if (pick < 35)      op = OP_RAW;
    else if (pick < 82) op = OP_RANGE;
    else if (pick < 93) op = OP_RESTART;
    else                op = OP_UNUSED;
    if (op == OP_RANGE) begin
      pick_range(lo, hi);
    end else begin
      lo = $urandom;
      hi = $urandom;
    end
    send_word(op, lo, hi);
  endtask

  // Main sequence
  initial begin
    logic [31:0] seeds [NUM_SEEDS];
    seeds = '{32'd0, 32'hFFFF_FFFF, 32'h0, 32'd1, 32'h8000_0000, 32'h0};
    seeds[2] = $urandom;
    seeds[5] = $urandom;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = OP_RAW;
    in_range_low   = 32'd0;
    in_range_high  = 32'd0;
    cfg_valid      = 1'b0;
    cfg_seed_value = 32'd0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset seed
    send_word(OP_RAW,     32'd0,         32'd0);
    send_word(OP_RAW,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_RANGE,   32'd0,         32'd0);
    send_word(OP_RANGE,   32'hFFFF_FFFF, 32'd0);
    send_word(OP_RANGE,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_RANGE,   32'd0,         32'hFFFF_FFFF);
    send_word(OP_RANGE,   32'd0,         32'd1);
    send_word(OP_RANGE,   32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_word(OP_RANGE,   32'd5,         32'd4);
    send_word(OP_UNUSED,  32'd0,         32'd0);
    send_word(OP_UNUSED,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_RESTART, 32'hFFFF_FFFF, 32'd0);
    send_word(OP_RAW,     32'h5555_5555, 32'hAAAA_AAAA);
    send_word(OP_RANGE,   32'd100,       32'd1100);
    send_word(OP_RANGE,   32'd0,         32'hFFFF_FFFF);
    send_word(OP_RESTART, 32'd0,         32'd0);
    send_word(OP_RAW,     32'd0,         32'd0);
    drain_results();

    // Random words under each seed, drained between seeds
    for (int s = 0; s < NUM_SEEDS; s++) begin
      write_seed(seeds[s]);
      if (s == 2) begin
        // receiver holds off while the sender keeps going
        @(posedge clk);
        hold_request = 1'b1;
      end
      burst_left = 0;
      for (int n = 0; n < WORDS_PER_SET; n++) send_random_word();
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d raw, %0d range, %0d empty range, %0d restart, %0d unused words",
             raw_sent, range_sent, empty_sent, restart_sent, unused_sent);
    $display("over %0d seed writes, %0d mismatches, %0d cycles",
             seed_writes, mismatches, cycle_count);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
